/* rtl/irkdp_pkg.sv */
// Shared constants, control types and microcode table of the int8 row kernel dot product block.
package irkdp_pkg;

    localparam int NUM_KERNELS  = 8;
    localparam int KERNEL_TAPS  = 16;
    localparam int K_W          = (NUM_KERNELS > 1) ? $clog2(NUM_KERNELS) : 1;
    localparam int T_W          = (KERNEL_TAPS > 1) ? $clog2(KERNEL_TAPS) : 1;
    localparam int ADDR_W       = K_W + T_W;
    localparam int WEIGHT_DEPTH = 1 << ADDR_W;

    localparam logic KIND_WEIGHT = 1'b0;
    localparam logic KIND_DATA   = 1'b1;

    typedef enum logic [1:0] {
        STEP_IDLE,
        STEP_MAC,
        STEP_EMIT
    } step_t;

    typedef enum logic [1:0] {
        COND_DATA_IN,
        COND_KERNEL_LAST,
        COND_EMIT_LAST
    } cond_t;

    // One microcode word: datapath enables, the jump condition, a row check and the jump target.
    typedef struct packed {
        logic  accept_en;
        logic  mac_en;
        logic  emit_en;
        cond_t cond;
        logic  row_check;
        step_t hit_step;
    } uword_t;

    typedef struct packed {
        logic accept_en;
        logic mac_en;
        logic emit_en;
    } ctrl_t;

    typedef struct packed {
        logic data_accept;
        logic k_last;
        logic row_end;
        logic out_free;
    } status_t;

    function automatic uword_t ucode_rom(step_t step);
        uword_t word;
        case (step)
            STEP_IDLE: begin
                word = '{accept_en: 1'b1, mac_en: 1'b0, emit_en: 1'b0,
                         cond: COND_DATA_IN, row_check: 1'b0, hit_step: STEP_MAC};
            end
            STEP_MAC: begin
                word = '{accept_en: 1'b0, mac_en: 1'b1, emit_en: 1'b0,
                         cond: COND_KERNEL_LAST, row_check: 1'b1, hit_step: STEP_EMIT};
            end
            STEP_EMIT: begin
                word = '{accept_en: 1'b0, mac_en: 1'b0, emit_en: 1'b1,
                         cond: COND_EMIT_LAST, row_check: 1'b0, hit_step: STEP_IDLE};
            end
            default: begin
                word = '{accept_en: 1'b0, mac_en: 1'b0, emit_en: 1'b0,
                         cond: COND_DATA_IN, row_check: 1'b0, hit_step: STEP_IDLE};
            end
        endcase
        return word;
    endfunction

endpackage

/* rtl/int8_row_kernel_dot_products.sv */
// Top level of the int8 row kernel dot product block: sequencer plus datapath.
//
// Input channel (s_*): each transfer is a weight load (s_kind = 0) that writes
// s_value at kernel s_kernel_index, tap s_tap_index, or a data byte (s_kind = 1).
// A weight load is taken while the block is idle. A data byte is accepted
// in one accept step, then gets one shared multiply-accumulate step per
// kernel, each fed by the weight memory's single registered read port.
// After the last byte of a row the block emits NUM_KERNELS results on the
// m_* channel in kernel order, m_last set on the final one, at one transfer
// per cycle while m_ready is high; the accumulators clear as they are emitted.
// The first result is registered by the first emit step after the accumulate
// steps of the row's last byte; the input stays closed until all are emitted.
// When the receiver stalls, the emit steps hold; the output register lets the
// block accept the next item while the final result of a row still waits.
// Reset clears the accumulators, the column count and the output valid; the
// weight memory is not cleared and must be loaded before use.
module int8_row_kernel_dot_products (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [2:0]         s_kernel_index,
    input  logic [3:0]         s_tap_index,
    input  logic signed [7:0]  s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_result_kernel,
    output logic signed [15:0] m_dot_sum,
    output logic               m_last
);

    irkdp_pkg::ctrl_t   ctrl;
    irkdp_pkg::status_t status;

    irkdp_ucode_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .status_i (status),
        .ctrl_o   (ctrl)
    );

    irkdp_datapath u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctrl_i          (ctrl),
        .status_o        (status),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_kernel_index  (s_kernel_index),
        .s_tap_index     (s_tap_index),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kernel (m_result_kernel),
        .m_dot_sum       (m_dot_sum),
        .m_last          (m_last)
    );

endmodule

/* rtl/irkdp_ucode_seq.sv */
// Microcode sequencer: step counter, control word table and conditional jumps.
module irkdp_ucode_seq (
    input  logic               aclk,
    input  logic               aresetn,
    input  irkdp_pkg::status_t status_i,
    output irkdp_pkg::ctrl_t   ctrl_o
);

    irkdp_pkg::step_t  step_reg;
    irkdp_pkg::step_t  step_next;
    irkdp_pkg::uword_t word;
    logic              hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= irkdp_pkg::STEP_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    always_comb begin
        word             = irkdp_pkg::ucode_rom(step_reg);
        ctrl_o.accept_en = word.accept_en;
        ctrl_o.mac_en    = word.mac_en;
        ctrl_o.emit_en   = word.emit_en;

        case (word.cond)
            irkdp_pkg::COND_DATA_IN:     hit = status_i.data_accept;
            irkdp_pkg::COND_KERNEL_LAST: hit = status_i.k_last;
            irkdp_pkg::COND_EMIT_LAST:   hit = status_i.k_last && status_i.out_free;
            default:                     hit = 1'b0;
        endcase

        step_next = step_reg;
        if (hit) begin
            // A byte that does not close its row returns to idle instead of emitting.
            if (word.row_check && !status_i.row_end) begin
                step_next = irkdp_pkg::STEP_IDLE;
            end else begin
                step_next = word.hit_step;
            end
        end
    end

endmodule

/* rtl/irkdp_datapath.sv */
// Datapath: weight memory, shared multiply-accumulate, accumulators and result register.
module irkdp_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  irkdp_pkg::ctrl_t   ctrl_i,
    output irkdp_pkg::status_t status_o,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_kind,
    input  logic [2:0]         s_kernel_index,
    input  logic [3:0]         s_tap_index,
    input  logic signed [7:0]  s_value,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_result_kernel,
    output logic signed [15:0] m_dot_sum,
    output logic               m_last
);

    logic signed [7:0]  weight_mem [irkdp_pkg::WEIGHT_DEPTH];
    logic signed [7:0]  rd_data_reg;
    logic [irkdp_pkg::ADDR_W-1:0] rd_addr;
    logic [irkdp_pkg::ADDR_W-1:0] wr_addr;
    logic               wr_en;

    logic signed [15:0] acc_reg  [irkdp_pkg::NUM_KERNELS];
    logic signed [15:0] acc_next [irkdp_pkg::NUM_KERNELS];
    logic [irkdp_pkg::K_W-1:0] k_reg, k_next;
    logic [irkdp_pkg::T_W-1:0] col_reg, col_next;
    logic [irkdp_pkg::T_W-1:0] byte_col_reg, byte_col_next;
    logic               row_end_reg, row_end_next;
    logic signed [7:0]  value_reg, value_next;

    logic               m_valid_reg, m_valid_next;
    logic [2:0]         m_kernel_reg, m_kernel_next;
    logic signed [15:0] m_sum_reg, m_sum_next;
    logic               m_last_reg, m_last_next;

    logic               s_fire;
    logic               data_accept;
    logic               k_last;
    logic               out_free;
    logic               emit_fire;
    logic signed [15:0] product;

    assign s_ready     = ctrl_i.accept_en;
    assign s_fire      = s_valid && s_ready;
    assign data_accept = s_fire && (s_kind == irkdp_pkg::KIND_DATA);
    assign k_last      = (k_reg == irkdp_pkg::K_W'(irkdp_pkg::NUM_KERNELS - 1));
    assign out_free    = !m_valid_reg || m_ready;
    assign emit_fire   = ctrl_i.emit_en && out_free;
    assign product     = 16'(value_reg) * 16'(rd_data_reg);

    assign wr_en = s_fire && (s_kind == irkdp_pkg::KIND_WEIGHT)
                   && (32'(s_kernel_index) < 32'(irkdp_pkg::NUM_KERNELS))
                   && (32'(s_tap_index) < 32'(irkdp_pkg::KERNEL_TAPS));
    assign wr_addr = {s_kernel_index[irkdp_pkg::K_W-1:0], s_tap_index[irkdp_pkg::T_W-1:0]};

    // The weight for kernel k is read into rd_data_reg in the cycle before its accumulate step.
    always_comb begin
        if (ctrl_i.mac_en) begin
            rd_addr = {k_reg + irkdp_pkg::K_W'(1), byte_col_reg};
        end else begin
            rd_addr = {irkdp_pkg::K_W'(0), col_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            weight_mem[wr_addr] <= s_value;
        end
        rd_data_reg <= weight_mem[rd_addr];
    end

    always_comb begin
        acc_next      = acc_reg;
        k_next        = k_reg;
        col_next      = col_reg;
        byte_col_next = byte_col_reg;
        row_end_next  = row_end_reg;
        value_next    = value_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_kernel_next = m_kernel_reg;
        m_sum_next    = m_sum_reg;
        m_last_next   = m_last_reg;

        if (data_accept) begin
            value_next    = s_value;
            byte_col_next = col_reg;
            k_next        = '0;
            row_end_next  = (col_reg == irkdp_pkg::T_W'(irkdp_pkg::KERNEL_TAPS - 1));
            col_next      = row_end_next ? '0 : col_reg + irkdp_pkg::T_W'(1);
        end

        if (ctrl_i.mac_en) begin
            acc_next[k_reg] = acc_reg[k_reg] + product;
            k_next          = k_last ? '0 : k_reg + irkdp_pkg::K_W'(1);
        end

        if (emit_fire) begin
            m_valid_next    = 1'b1;
            m_kernel_next   = 3'(k_reg);
            m_sum_next      = acc_reg[k_reg];
            m_last_next     = k_last;
            acc_next[k_reg] = '0;
            k_next          = k_last ? '0 : k_reg + irkdp_pkg::K_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < irkdp_pkg::NUM_KERNELS; i++) begin
                acc_reg[i] <= '0;
            end
            k_reg       <= '0;
            col_reg     <= '0;
            row_end_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            k_reg       <= k_next;
            col_reg     <= col_next;
            row_end_reg <= row_end_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        byte_col_reg <= byte_col_next;
        value_reg    <= value_next;
        m_kernel_reg <= m_kernel_next;
        m_sum_reg    <= m_sum_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_result_kernel = m_kernel_reg;
    assign m_dot_sum       = m_sum_reg;
    assign m_last          = m_last_reg;

    assign status_o.data_accept = data_accept;
    assign status_o.k_last      = k_last;
    assign status_o.row_end     = row_end_reg;
    assign status_o.out_free    = out_free;

    a_data_starts_mac: assert property (@(posedge aclk) disable iff (!aresetn)
        data_accept |=> ctrl_i.mac_en && (k_reg == '0))
        else $error("data byte did not start the accumulate pass at kernel zero");

    a_row_end_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl_i.mac_en && k_last && row_end_reg |=> ctrl_i.emit_en && (k_reg == '0))
        else $error("row end did not lead to emitting from kernel zero");

    a_last_emit_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire && k_last |=> ctrl_i.accept_en && m_valid && m_last)
        else $error("final result of a row did not return the block to idle");

    a_emit_loads_output: assert property (@(posedge aclk) disable iff (!aresetn)
        emit_fire |=> m_valid && (m_result_kernel == 3'($past(k_reg))))
        else $error("emitted result did not reach the output register");

endmodule

/* sim/int8_row_kernel_dot_products_test.sv */
// Self-checking testbench for the int8 row kernel dot product block.
`timescale 1ns / 1ps

module int8_row_kernel_dot_products_test;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RANDOM_ITEMS   = 80;

    typedef enum logic [1:0] {
        ROW_LOAD,
        ROW_FILL,
        ROW_DATA
    } stim_op_t;

    typedef struct {
        stim_op_t           op;
        logic [2:0]         kernel;
        logic [3:0]         tap;
        logic signed [7:0]  value;
        int                 count;
        bit                 has_sum;
        logic signed [15:0] fixed_sum;
    } stim_row_t;

    typedef struct {
        logic [2:0]         kernel;
        logic signed [15:0] sum;
        logic               last;
    } dot_result_t;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_kind;
    logic [2:0]         s_kernel_index;
    logic [3:0]         s_tap_index;
    logic signed [7:0]  s_value;
    logic               m_valid;
    logic               m_ready;
    logic [2:0]         m_result_kernel;
    logic signed [15:0] m_dot_sum;
    logic               m_last;

    // Predictor state.
    logic signed [7:0] kernel_weights [irkdp_pkg::NUM_KERNELS][irkdp_pkg::KERNEL_TAPS];
    logic [15:0]       row_sums [irkdp_pkg::NUM_KERNELS];
    int                row_column;

    dot_result_t expected_dots [$];
    stim_row_t   stim_table [$];
    int          dot_errors;
    int          sent_items;
    int          burst_left;
    bit          hold_request;

    int8_row_kernel_dot_products uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_kind          (s_kind),
        .s_kernel_index  (s_kernel_index),
        .s_tap_index     (s_tap_index),
        .s_value         (s_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_result_kernel (m_result_kernel),
        .m_dot_sum       (m_dot_sum),
        .m_last          (m_last)
    );

    always begin
        aclk = 1'b0;
        #4;
        aclk = 1'b1;
        #4;
    end

    // Updates the predicted weights and sums for one accepted item and queues any row results.
    task automatic accumulate_item(input logic kind, input logic [2:0] kidx,
                                   input logic [3:0] tidx, input logic signed [7:0] value,
                                   input bit use_fixed, input logic signed [15:0] fixed_sum);
        int prod;
        dot_result_t res;
        if (kind == irkdp_pkg::KIND_WEIGHT) begin
            kernel_weights[kidx][tidx] = value;
        end else begin
            for (int k = 0; k < irkdp_pkg::NUM_KERNELS; k++) begin
                prod = int'(value) * int'(kernel_weights[k][row_column]);
                row_sums[k] = row_sums[k] + prod[15:0];
            end
            row_column++;
            if (row_column == irkdp_pkg::KERNEL_TAPS) begin
                for (int k = 0; k < irkdp_pkg::NUM_KERNELS; k++) begin
                    res.kernel = 3'(k);
                    res.sum = use_fixed ? fixed_sum : row_sums[k];
                    res.last = (k == irkdp_pkg::NUM_KERNELS - 1);
                    expected_dots.push_back(res);
                    row_sums[k] = '0;
                end
                row_column = 0;
            end
        end
    endtask

    // Offers one item, waits for its transfer, then maybe ends the current burst.
    task automatic transfer_item(input logic kind, input logic [2:0] kidx,
                                 input logic [3:0] tidx, input logic signed [7:0] value,
                                 input bit use_fixed, input logic signed [15:0] fixed_sum);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3)
                                                     : $urandom_range(5, 60);
        end
        s_valid        <= 1'b1;
        s_kind         <= kind;
        s_kernel_index <= kidx;
        s_tap_index    <= tidx;
        s_value        <= value;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        accumulate_item(kind, kidx, tidx, value, use_fixed, fixed_sum);
        sent_items++;
        burst_left--;
        if (burst_left == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge aclk);
        end
    endtask

    function automatic logic signed [7:0] pick_byte();
        case ($urandom_range(0, 11))
            0: return -8'sd128;
            1: return 8'sd127;
            2: return 8'sd0;
            3: return -8'sd1;
            default: return 8'($urandom);
        endcase
    endfunction

    // Result checker.
    always @(posedge aclk) begin
        dot_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_dots.size() == 0) begin
                dot_errors++;
                if (dot_errors <= 10) begin
                    $display("unexpected result: kernel %0d sum %0d last %0b",
                             m_result_kernel, m_dot_sum, m_last);
                end
            end else begin
                want = expected_dots.pop_front();
                if (m_result_kernel !== want.kernel || m_dot_sum !== want.sum
                        || m_last !== want.last) begin
                    dot_errors++;
                    if (dot_errors <= 10) begin
                        $display("result mismatch: expected kernel %0d sum %0d last %0b, got kernel %0d sum %0d last %0b",
                                 want.kernel, want.sum, want.last,
                                 m_result_kernel, m_dot_sum, m_last);
                    end
                end
            end
        end
    end

    // Receiver: stalls on its own changing pattern, with a long hold-off on each request.
    initial begin : receiver
        int mode;
        int span;
        int phase;
        m_ready <= 1'b0;
        @(posedge aclk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(5, 60);
            phase = 0;
            repeat (span) begin
                case (mode)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom);
                    2: m_ready <= (phase % 3 == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
                phase++;
                @(posedge aclk);
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any transfer.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("int8_row_kernel_dot_products_test failed");
        $finish;
    end

    initial begin : stimulus
        stim_row_t row;
        int stop_at;
        int pick;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_kind         = irkdp_pkg::KIND_WEIGHT;
        s_kernel_index = '0;
        s_tap_index    = '0;
        s_value        = '0;
        dot_errors     = 0;
        sent_items     = 0;
        burst_left     = 0;
        hold_request   = 1'b0;
        row_column     = 0;
        for (int k = 0; k < irkdp_pkg::NUM_KERNELS; k++) begin
            row_sums[k] = '0;
            for (int t = 0; t < irkdp_pkg::KERNEL_TAPS; t++) begin
                kernel_weights[k][t] = '0;
            end
        end

        // Every weight is written first, so no accumulate step ever uses an unloaded entry.
        // Full rows against all weights at -128 show the 16-bit wrap directly.
        stim_table.push_back('{ROW_FILL, 3'd0, 4'd0, -8'sd128, 1, 1'b0, 16'sd0});
        stim_table.push_back('{ROW_DATA, 3'd0, 4'd0, 8'sd127, 16, 1'b1, 16'sd2048});
        stim_table.push_back('{ROW_DATA, 3'd7, 4'd15, -8'sd128, 16, 1'b1, 16'sd0});
        stim_table.push_back('{ROW_DATA, 3'd0, 4'd0, 8'sd1, 16, 1'b1, -16'sd2048});
        stim_table.push_back('{ROW_LOAD, 3'd0, 4'd0, 8'sd127, 1, 1'b0, 16'sd0});
        stim_table.push_back('{ROW_LOAD, 3'd7, 4'd15, 8'sd127, 1, 1'b0, 16'sd0});
        // Loads in mid-row: one behind the current column, one ahead of it.
        stim_table.push_back('{ROW_DATA, 3'd5, 4'd9, 8'sd1, 5, 1'b0, 16'sd0});
        stim_table.push_back('{ROW_LOAD, 3'd3, 4'd2, 8'sd5, 1, 1'b0, 16'sd0});
        stim_table.push_back('{ROW_LOAD, 3'd3, 4'd10, -8'sd7, 1, 1'b0, 16'sd0});
        stim_table.push_back('{ROW_DATA, 3'd2, 4'd6, -8'sd1, 11, 1'b0, 16'sd0});
        stim_table.push_back('{ROW_DATA, 3'd0, 4'd0, 8'sd0, 16, 1'b1, 16'sd0});
        stim_table.push_back('{ROW_DATA, 3'd0, 4'd0, 8'sd127, 16, 1'b0, 16'sd0});

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (stim_table[i]) begin
            row = stim_table[i];
            case (row.op)
                ROW_FILL: begin
                    for (int k = 0; k < irkdp_pkg::NUM_KERNELS; k++) begin
                        for (int t = 0; t < irkdp_pkg::KERNEL_TAPS; t++) begin
                            transfer_item(irkdp_pkg::KIND_WEIGHT, 3'(k), 4'(t), row.value,
                                          1'b0, 16'sd0);
                        end
                    end
                end
                ROW_LOAD: begin
                    transfer_item(irkdp_pkg::KIND_WEIGHT, row.kernel, row.tap, row.value,
                                  1'b0, 16'sd0);
                end
                default: begin
                    for (int n = 0; n < row.count; n++) begin
                        transfer_item(irkdp_pkg::KIND_DATA, row.kernel, row.tap, row.value,
                                      row.has_sum && (n == row.count - 1), row.fixed_sum);
                    end
                end
            endcase
        end

        // Mostly whole rows with sparse weight updates; some loose loads and noise.
        stop_at = sent_items + RANDOM_ITEMS;
        while (sent_items < stop_at) begin
            if (sent_items > stop_at - RANDOM_ITEMS + 10 && sent_items < stop_at - 30) begin
                hold_request = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 7) begin
                repeat (irkdp_pkg::KERNEL_TAPS) begin
                    if ($urandom_range(0, 7) == 0) begin
                        transfer_item(irkdp_pkg::KIND_WEIGHT, 3'($urandom), 4'($urandom),
                                      pick_byte(), 1'b0, 16'sd0);
                    end
                    transfer_item(irkdp_pkg::KIND_DATA, 3'($urandom), 4'($urandom),
                                  pick_byte(), 1'b0, 16'sd0);
                end
            end else if (pick < 9) begin
                repeat ($urandom_range(1, 4)) begin
                    transfer_item(irkdp_pkg::KIND_WEIGHT, 3'($urandom), 4'($urandom),
                                  pick_byte(), 1'b0, 16'sd0);
                end
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    transfer_item(1'($urandom), 3'($urandom), 4'($urandom), pick_byte(),
                                  1'b0, 16'sd0);
                end
            end
        end
        if (burst_left != 0) begin
            s_valid <= 1'b0;
        end

        while (expected_dots.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (dot_errors == 0 && expected_dots.size() == 0) begin
            $display("int8_row_kernel_dot_products_test passed");
        end else begin
            $display("int8_row_kernel_dot_products_test failed");
        end
        $finish;
    end

endmodule
